// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interpolator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tbi_pkg.sv
// ----------------------------------------------------------------------------
// tbi_pkg
// Constants shared by the barycentric interpolator and its interfaces.
// ----------------------------------------------------------------------------
package tbi_pkg;

    localparam int COORD_BITS_DEF       = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int LIMIT_BITS           = 32;
    localparam logic [LIMIT_BITS-1:0] DEG_LIMIT_RESET = 32'd4295;
    // Width of one weight slice fed to a partial-product multiplier.
    localparam int MUL_CHUNK            = 30;

endpackage

// File: hdl/tbi_if.sv
// ----------------------------------------------------------------------------
// tbi interfaces
// Valid/ready channels for query items, result items and the limit register.
// ----------------------------------------------------------------------------
interface tbi_item_if #(parameter int W = tbi_pkg::COORD_BITS_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] corner_a_x;
    logic signed [W-1:0] corner_a_y;
    logic signed [W-1:0] corner_a_z;
    logic signed [W-1:0] corner_b_x;
    logic signed [W-1:0] corner_b_y;
    logic signed [W-1:0] corner_b_z;
    logic signed [W-1:0] corner_c_x;
    logic signed [W-1:0] corner_c_y;
    logic signed [W-1:0] corner_c_z;
    logic signed [W-1:0] query_x;
    logic signed [W-1:0] query_y;
    logic signed [W-1:0] query_z;

    modport source (output valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x,
                    corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
                    query_x, query_y, query_z, input ready);
    modport sink   (input valid, corner_a_x, corner_a_y, corner_a_z, corner_b_x,
                    corner_b_y, corner_b_z, corner_c_x, corner_c_y, corner_c_z,
                    query_x, query_y, query_z, output ready);
endinterface

interface tbi_result_if #(parameter int W = tbi_pkg::COORD_BITS_DEF);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] result_x;
    logic signed [W-1:0] result_y;
    logic signed [W-1:0] result_z;
    logic                degenerate;

    modport source (output valid, result_x, result_y, result_z, degenerate, input ready);
    modport sink   (input valid, result_x, result_y, result_z, degenerate, output ready);
endinterface

interface tbi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbi_pkg::LIMIT_BITS-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: hdl/triangle_barycentric_interp.sv
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The restoring divider resolves one quotient bit per stage.
// Reset clears all valid bits and loads the degenerate limit with 4295.
// ----------------------------------------------------------------------------
// triangle_barycentric_interp
// Pipelined barycentric weights by exact division and interpolation of corners.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_barycentric_interp #(
    parameter int COORD_BITS       = tbi_pkg::COORD_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = tbi_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tbi_item_if.sink    item,
    tbi_result_if.source result,
    tbi_cfg_if.sink     cfg
);
    import tbi_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = WEIGHT_FRAC_BITS;
    localparam int E    = C + 1;
    localparam int PR   = 2 * E;
    localparam int D    = PR + 2;
    localparam int BW   = 2 * D;
    localparam int DN   = BW + 1;
    localparam int MAGD = DN - 1;
    localparam int NQ   = DN - 1 + F;
    localparam int QW   = NQ + 1;
    localparam int CH   = MUL_CHUNK;
    localparam int K    = (QW + CH - 1) / CH;
    localparam int PW   = CH + 1 + E;
    localparam int SW   = K * CH + E + 3;
    localparam int NST  = NQ + 10;

    typedef struct packed {
        logic [MAGD:0]           rem_v;
        logic [NQ-1:0]           num_v;
        logic [MAGD:0]           rem_w;
        logic [NQ-1:0]           num_w;
        logic [MAGD-1:0]         den;
        logic                    neg_v;
        logic                    neg_w;
        logic                    deg;
        logic [2:0][C-1:0]       a;
        logic [2:0][E-1:0]       e0;
        logic [2:0][E-1:0]       e1;
    } div_t;

    logic [NST-1:0]        vld_reg, vld_next;
    logic [LIMIT_BITS-1:0] limit_reg, limit_next;
    logic                  adv;

    logic signed [C-1:0]  a_in [3];
    logic signed [C-1:0]  b_in [3];
    logic signed [C-1:0]  c_in [3];
    logic signed [C-1:0]  p_in [3];

    logic signed [C-1:0]  a1_reg [3], a2_reg [3], a3_reg [3], a4_reg [3], a5_reg [3];
    logic signed [E-1:0]  e0_1_reg [3], e1_1_reg [3], e2_1_reg [3];
    logic signed [E-1:0]  e0_2_reg [3], e1_2_reg [3], e0_3_reg [3], e1_3_reg [3];
    logic signed [E-1:0]  e0_4_reg [3], e1_4_reg [3], e0_5_reg [3], e1_5_reg [3];
    logic signed [PR-1:0] p00_reg [3], p01_reg [3], p11_reg [3], p20_reg [3], p21_reg [3];
    logic signed [D-1:0]  d00_reg, d01_reg, d11_reg, d20_reg, d21_reg;
    logic signed [BW-1:0] ma_reg, mb_reg, mc_reg, md_reg, me_reg, mf_reg;
    logic signed [DN-1:0] den_reg, nv_reg, nw_reg;

    div_t div_reg  [NQ+1];
    div_t div_next [NQ+1];

    logic signed [QW-1:0] qv_reg, qw_reg;
    logic [2:0][C-1:0]    a7_reg, a8_reg, a9_reg;
    logic [2:0][E-1:0]    e0_7_reg, e1_7_reg;
    logic                 deg7_reg, deg8_reg, deg9_reg;
    logic signed [PW-1:0] pv_reg [3][K];
    logic signed [PW-1:0] pw_reg [3][K];
    logic signed [SW-1:0] s_reg [3];
    logic signed [C-1:0]  res_reg [3];
    logic                 deg_out_reg;

    assign adv        = !vld_reg[NST-1] || result.ready;
    assign item.ready = adv;
    assign cfg.ready  = 1'b1;
    assign vld_next   = {vld_reg[NST-2:0], item.valid};
    assign limit_next = (cfg.valid && cfg.ready) ? cfg.data : limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            limit_reg <= DEG_LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
            if (adv)
            begin
                vld_reg <= vld_next;
            end
        end
    end

    assign a_in = '{item.corner_a_x, item.corner_a_y, item.corner_a_z};
    assign b_in = '{item.corner_b_x, item.corner_b_y, item.corner_b_z};
    assign c_in = '{item.corner_c_x, item.corner_c_y, item.corner_c_z};
    assign p_in = '{item.query_x, item.query_y, item.query_z};

    // Front stages: edges, products, dot sums, products of dot sums, differences.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a1_reg[k]   <= a_in[k];
                e0_1_reg[k] <= E'(b_in[k]) - E'(a_in[k]);
                e1_1_reg[k] <= E'(c_in[k]) - E'(a_in[k]);
                e2_1_reg[k] <= E'(p_in[k]) - E'(a_in[k]);

                a2_reg[k]   <= a1_reg[k];
                e0_2_reg[k] <= e0_1_reg[k];
                e1_2_reg[k] <= e1_1_reg[k];
                p00_reg[k]  <= e0_1_reg[k] * e0_1_reg[k];
                p01_reg[k]  <= e0_1_reg[k] * e1_1_reg[k];
                p11_reg[k]  <= e1_1_reg[k] * e1_1_reg[k];
                p20_reg[k]  <= e2_1_reg[k] * e0_1_reg[k];
                p21_reg[k]  <= e2_1_reg[k] * e1_1_reg[k];

                a3_reg[k]   <= a2_reg[k];
                e0_3_reg[k] <= e0_2_reg[k];
                e1_3_reg[k] <= e1_2_reg[k];
                a4_reg[k]   <= a3_reg[k];
                e0_4_reg[k] <= e0_3_reg[k];
                e1_4_reg[k] <= e1_3_reg[k];
                a5_reg[k]   <= a4_reg[k];
                e0_5_reg[k] <= e0_4_reg[k];
                e1_5_reg[k] <= e1_4_reg[k];
            end
            d00_reg <= D'(p00_reg[0]) + D'(p00_reg[1]) + D'(p00_reg[2]);
            d01_reg <= D'(p01_reg[0]) + D'(p01_reg[1]) + D'(p01_reg[2]);
            d11_reg <= D'(p11_reg[0]) + D'(p11_reg[1]) + D'(p11_reg[2]);
            d20_reg <= D'(p20_reg[0]) + D'(p20_reg[1]) + D'(p20_reg[2]);
            d21_reg <= D'(p21_reg[0]) + D'(p21_reg[1]) + D'(p21_reg[2]);

            ma_reg <= d00_reg * d11_reg;
            mb_reg <= d01_reg * d01_reg;
            mc_reg <= d11_reg * d20_reg;
            md_reg <= d01_reg * d21_reg;
            me_reg <= d00_reg * d21_reg;
            mf_reg <= d01_reg * d20_reg;

            den_reg <= DN'(ma_reg) - DN'(mb_reg);
            nv_reg  <= DN'(mc_reg) - DN'(md_reg);
            nw_reg  <= DN'(me_reg) - DN'(mf_reg);
        end
    end

    // Magnitudes, degenerate test and divider load.
    logic signed [DN-1:0] den_neg, nv_neg, nw_neg;
    logic [MAGD-1:0]      den_mag, nv_mag, nw_mag;

    assign den_neg = -den_reg;
    assign nv_neg  = -nv_reg;
    assign nw_neg  = -nw_reg;
    assign den_mag = den_reg[DN-1] ? den_neg[MAGD-1:0] : den_reg[MAGD-1:0];
    assign nv_mag  = nv_reg[DN-1] ? nv_neg[MAGD-1:0] : nv_reg[MAGD-1:0];
    assign nw_mag  = nw_reg[DN-1] ? nw_neg[MAGD-1:0] : nw_reg[MAGD-1:0];

    always_comb
    begin
        div_next[0].rem_v = '0;
        div_next[0].rem_w = '0;
        div_next[0].num_v = {nv_mag, {F{1'b0}}};
        div_next[0].num_w = {nw_mag, {F{1'b0}}};
        div_next[0].den   = den_mag;
        div_next[0].neg_v = nv_reg[DN-1];
        div_next[0].neg_w = nw_reg[DN-1];
        div_next[0].deg   = (den_mag == '0) ||
                            (den_mag < {{(MAGD-LIMIT_BITS){1'b0}}, limit_reg});
        for (int k = 0; k < 3; k++)
        begin
            div_next[0].a[k]  = a5_reg[k];
            div_next[0].e0[k] = e0_5_reg[k];
            div_next[0].e1[k] = e1_5_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_reg[0] <= div_next[0];
        end
    end

    // Restoring divider, one quotient bit per stage for both weights.
    for (genvar j = 0; j < NQ; j++)
    begin : g_div
        logic [MAGD:0] tv, tw, dd;
        logic          gev, gew;

        assign dd  = {1'b0, div_reg[j].den};
        assign tv  = {div_reg[j].rem_v[MAGD-1:0], div_reg[j].num_v[NQ-1]};
        assign tw  = {div_reg[j].rem_w[MAGD-1:0], div_reg[j].num_w[NQ-1]};
        assign gev = (tv >= dd);
        assign gew = (tw >= dd);

        always_comb
        begin
            div_next[j+1]       = div_reg[j];
            div_next[j+1].rem_v = gev ? (tv - dd) : tv;
            div_next[j+1].rem_w = gew ? (tw - dd) : tw;
            div_next[j+1].num_v = {div_reg[j].num_v[NQ-2:0], gev};
            div_next[j+1].num_w = {div_reg[j].num_w[NQ-2:0], gew};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_reg[j+1] <= div_next[j+1];
            end
        end
    end

    // Back stages: signed weights, partial products, sum, round and saturate, or corner A when degenerate.
    logic [K*CH-1:0]      vx, wx;
    logic signed [SW-1:0] s_next [3];
    logic signed [SW-1:0] t_round [3];
    logic signed [C-1:0]  sat [3];

    assign vx = (K*CH)'(qv_reg);
    assign wx = (K*CH)'(qw_reg);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            s_next[k] = SW'($signed(a8_reg[k])) <<< F;
            for (int j = 0; j < K; j++)
            begin
                s_next[k] = s_next[k] + (SW'(pv_reg[k][j]) <<< (j*CH))
                                      + (SW'(pw_reg[k][j]) <<< (j*CH));
            end
            t_round[k] = (s_reg[k] + (SW'(1) <<< (F-1))) >>> F;
            if ((&t_round[k][SW-1:C-1]) || !(|t_round[k][SW-1:C-1]))
            begin
                sat[k] = t_round[k][C-1:0];
            end
            else
            begin
                sat[k] = t_round[k][SW-1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qv_reg   <= div_reg[NQ].neg_v ? -$signed({1'b0, div_reg[NQ].num_v})
                                          :  $signed({1'b0, div_reg[NQ].num_v});
            qw_reg   <= div_reg[NQ].neg_w ? -$signed({1'b0, div_reg[NQ].num_w})
                                          :  $signed({1'b0, div_reg[NQ].num_w});
            a7_reg   <= div_reg[NQ].a;
            e0_7_reg <= div_reg[NQ].e0;
            e1_7_reg <= div_reg[NQ].e1;
            deg7_reg <= div_reg[NQ].deg;

            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    if (j == K-1)
                    begin
                        pv_reg[k][j] <= $signed({vx[K*CH-1], vx[j*CH +: CH]})
                                        * $signed(e0_7_reg[k]);
                        pw_reg[k][j] <= $signed({wx[K*CH-1], wx[j*CH +: CH]})
                                        * $signed(e1_7_reg[k]);
                    end
                    else
                    begin
                        pv_reg[k][j] <= $signed({1'b0, vx[j*CH +: CH]})
                                        * $signed(e0_7_reg[k]);
                        pw_reg[k][j] <= $signed({1'b0, wx[j*CH +: CH]})
                                        * $signed(e1_7_reg[k]);
                    end
                end
                s_reg[k]   <= s_next[k];
                res_reg[k] <= deg9_reg ? $signed(a9_reg[k]) : sat[k];
            end
            a8_reg      <= a7_reg;
            deg8_reg    <= deg7_reg;
            a9_reg      <= a8_reg;
            deg9_reg    <= deg8_reg;
            deg_out_reg <= deg9_reg;
        end
    end

    assign result.valid      = vld_reg[NST-1];
    assign result.result_x   = res_reg[0];
    assign result.result_y   = res_reg[1];
    assign result.result_z   = res_reg[2];
    assign result.degenerate = deg_out_reg;

    `TBI_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(vld_reg), "valid bits moved during a stall")
    `TBI_ASSERT_NEXT(a_entry, clk, rst_n, item.valid && item.ready, vld_reg[0], "accepted item not tracked")
    `TBI_ASSERT_NEXT(a_cfg, clk, rst_n, cfg.valid && cfg.ready, limit_reg == $past(cfg.data), "limit write lost")

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barycentric interpolator testbench
// Drives triangle and query items through the valid/ready channels under
// several idling patterns and degenerate limits. Each accepted item is
// predicted with exact wide integer math and the results are checked in order.
// ----------------------------------------------------------------------------
module tb_top;

    import tbi_pkg::*;

    localparam int  CW          = COORD_BITS_DEF;
    localparam int  WF          = WEIGHT_FRAC_BITS_DEF;
    localparam int  DRAIN       = 120;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  N_RANDOM    = 125;

    typedef logic signed [CW-1:0]  coord_t;
    typedef logic signed [255:0]   wide_t;

    typedef struct {
        coord_t a[3];
        coord_t b[3];
        coord_t c[3];
        coord_t q[3];
    } tri_query_t;

    typedef struct {
        coord_t pos[3];
        logic   degenerate;
    } interp_t;

    class interp_scoreboard;
        interp_t               pending[$];
        logic [LIMIT_BITS-1:0] deg_limit;
        int                    errors;
        int                    checked;
        int                    degenerate_seen;

        function new();
            deg_limit = DEG_LIMIT_RESET;
        endfunction

        function interp_t interpolate(tri_query_t t);
            interp_t r;
            wide_t   a[3], b[3], c[3], e0[3], e1[3], e2[3];
            wide_t   d00, d01, d11, d20, d21, den, v, w, u, s;
            d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
            for (int k = 0; k < 3; k++)
            begin
                a[k] = t.a[k];
                b[k] = t.b[k];
                c[k] = t.c[k];
                e0[k] = b[k] - a[k];
                e1[k] = c[k] - a[k];
                e2[k] = wide_t'(t.q[k]) - a[k];
                d00 += e0[k] * e0[k];
                d01 += e0[k] * e1[k];
                d11 += e1[k] * e1[k];
                d20 += e2[k] * e0[k];
                d21 += e2[k] * e1[k];
            end
            den = d00 * d11 - d01 * d01;
            if (den < 0)
                den = -den;
            if (den == 0 || den < $signed({224'b0, deg_limit}))
            begin
                r.pos = t.a;
                r.degenerate = 1'b1;
                return r;
            end
            v = ((d11 * d20 - d01 * d21) <<< WF) / den;
            w = ((d00 * d21 - d01 * d20) <<< WF) / den;
            u = (wide_t'(1) <<< WF) - v - w;
            for (int k = 0; k < 3; k++)
            begin
                s = (u * a[k] + v * b[k] + w * c[k] + (wide_t'(1) <<< (WF - 1))) >>> WF;
                if (s > 32767)
                    r.pos[k] = 16'sh7fff;
                else if (s < -32768)
                    r.pos[k] = 16'sh8000;
                else
                    r.pos[k] = s[CW-1:0];
            end
            r.degenerate = 1'b0;
            return r;
        endfunction

        function void note_input(tri_query_t t);
            pending.push_back(interpolate(t));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] exp);
            errors++;
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $time);
        endtask

        task check_result(interp_t got);
            interp_t exp;
            checked++;
            if (pending.size() == 0)
            begin
                report("unexpected result", 0, 0);
                return;
            end
            exp = pending.pop_front();
            if (exp.degenerate)
                degenerate_seen++;
            for (int k = 0; k < 3; k++)
                if (got.pos[k] !== exp.pos[k])
                    report($sformatf("result coord %0d", k), 32'(got.pos[k]), 32'(exp.pos[k]));
            if (got.degenerate !== exp.degenerate)
                report("degenerate", 32'(got.degenerate), 32'(exp.degenerate));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   sender_idle_pct;
    int   receiver_stall_pct;
    int   items_sent;

    interp_scoreboard board;

    tbi_item_if   item();
    tbi_result_if result();
    tbi_cfg_if    cfg();

    triangle_barycentric_interp u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(negedge clk)
        result.ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);

    always @(posedge clk)
    begin
        tri_query_t t;
        interp_t    r;
        if (rst_n && item.valid && item.ready)
        begin
            t.a = '{item.corner_a_x, item.corner_a_y, item.corner_a_z};
            t.b = '{item.corner_b_x, item.corner_b_y, item.corner_b_z};
            t.c = '{item.corner_c_x, item.corner_c_y, item.corner_c_z};
            t.q = '{item.query_x, item.query_y, item.query_z};
            board.note_input(t);
        end
        if (rst_n && result.valid && result.ready)
        begin
            r.pos = '{result.result_x, result.result_y, result.result_z};
            r.degenerate = result.degenerate;
            board.check_result(r);
        end
    end

    task send_item(tri_query_t t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            item.valid = 1'b0;
        end
        @(negedge clk);
        item.valid = 1'b1;
        {item.corner_a_x, item.corner_a_y, item.corner_a_z} = {t.a[0], t.a[1], t.a[2]};
        {item.corner_b_x, item.corner_b_y, item.corner_b_z} = {t.b[0], t.b[1], t.b[2]};
        {item.corner_c_x, item.corner_c_y, item.corner_c_z} = {t.c[0], t.c[1], t.c[2]};
        {item.query_x, item.query_y, item.query_z} = {t.q[0], t.q[1], t.q[2]};
        do
            @(posedge clk);
        while (!item.ready);
        items_sent++;
    endtask

    task write_limit(logic [LIMIT_BITS-1:0] value);
        @(negedge clk);
        item.valid = 1'b0;
        cfg.valid = 1'b1;
        cfg.data = value;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.deg_limit = value;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task wait_idle();
        @(negedge clk);
        item.valid = 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function coord_t span_coord(int span);
        return coord_t'($urandom_range(2 * span) - span);
    endfunction

    function tri_query_t random_triangle();
        tri_query_t t;
        int         mode, span, f;
        mode = $urandom_range(9);
        span = (mode < 2) ? 32767 : ((mode == 9) ? 32000 : 2048);
        for (int k = 0; k < 3; k++)
        begin
            t.a[k] = (mode < 2) ? coord_t'($urandom) : span_coord(span);
            t.b[k] = (mode < 2) ? coord_t'($urandom) : span_coord(span);
            t.c[k] = (mode < 2) ? coord_t'($urandom) : span_coord(span);
            t.q[k] = (mode < 2) ? coord_t'($urandom) : span_coord(span);
        end
        if (mode == 7)
        begin
            f = $urandom_range(6) - 3;
            for (int k = 0; k < 3; k++)
            begin
                t.b[k] = t.a[k] + span_coord(200);
                t.c[k] = coord_t'(t.a[k] + f * (t.b[k] - t.a[k]));
            end
        end
        else if (mode == 8)
        begin
            for (int k = 0; k < 3; k++)
                t.q[k] = coord_t'((t.a[k] + t.b[k] + t.c[k]) / 3 + span_coord(4));
        end
        return t;
    endfunction

    function tri_query_t make_tri(int a0, int a1, int a2, int b0, int b1, int b2,
                                  int c0, int c1, int c2, int q0, int q1, int q2);
        tri_query_t t;
        t.a = '{coord_t'(a0), coord_t'(a1), coord_t'(a2)};
        t.b = '{coord_t'(b0), coord_t'(b1), coord_t'(b2)};
        t.c = '{coord_t'(c0), coord_t'(c1), coord_t'(c2)};
        t.q = '{coord_t'(q0), coord_t'(q1), coord_t'(q2)};
        return t;
    endfunction

    task run_directed();
        send_item(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 64, 64, 0));
        send_item(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 0, 0));
        send_item(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 0, 0));
        send_item(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0, 256, 0));
        send_item(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 85, 85, 5000));
        send_item(make_tri(10, 20, 30, 10, 20, 30, 10, 20, 30, 1, 2, 3));
        send_item(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 5, 0, 0));
        send_item(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0));
        send_item(make_tri(0, 0, 0, 16, 0, 0, 0, 16, 0, 8, 8, 0));
        send_item(make_tri(32767, 32767, 32767, -32768, -32768, -32768,
                           32767, -32768, 32767, -32768, 32767, -32768));
        send_item(make_tri(-32768, -32768, -32768, 32767, -32768, 0,
                           -32768, 32767, 0, 32767, 32767, 32767));
        send_item(make_tri(0, 0, 0, 32767, 0, 0, 0, 32767, 0, 32767, 32767, 0));
        send_item(make_tri(0, 0, 0, 10, 0, 0, 0, 10, 0, -32768, -32768, 0));
        send_item(make_tri(0, 0, 0, 10, 0, 0, 0, 10, 0, 32767, 32767, 0));
        send_item(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        send_item(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_tri(100, -200, 300, 356, -200, 300, 100, 56, 300, 228, -72, 300));
    endtask

    initial
    begin
        board = new();
        rst_n = 1'b0;
        cycles = 0;
        items_sent = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        item.valid = 1'b0;
        {item.corner_a_x, item.corner_a_y, item.corner_a_z} = '0;
        {item.corner_b_x, item.corner_b_y, item.corner_b_z} = '0;
        {item.corner_c_x, item.corner_c_y, item.corner_c_z} = '0;
        {item.query_x, item.query_y, item.query_z} = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        result.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        for (int phase = 0; phase < 4; phase++)
        begin
            wait_idle();
            case (phase)
                0: write_limit(32'd0);
                1: write_limit(32'hffff_ffff);
                2: write_limit($urandom);
                default: write_limit(DEG_LIMIT_RESET);
            endcase
            sender_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 75 : 21) : 0;
            receiver_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 75 : 21) : 0;
            if (phase == 0)
                run_directed();
            for (int n = 0; n < N_RANDOM; n++)
                send_item(random_triangle());
        end

        wait_idle();
        $display("Sent %0d items over four idling patterns and four limit settings.", items_sent);
        $display("Checked %0d results, %0d of them degenerate.", board.checked,
                 board.degenerate_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/tbi_pkg.sv
hdl/tbi_if.sv
hdl/triangle_barycentric_interp.sv
dv/tb_top.sv
